/* rtl/core/json_string_unescape_assert.svh */
// ----------------------------------------------------------------------------
// json_string_unescape_assert.svh
// Assertion macros for the string unescape RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// checked only out of reset
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define JSU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/jsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int LEN_W           = 16;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX_HI,
        MODE_SUR_BS,
        MODE_SUR_U,
        MODE_HEX_LO
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_FF    = 8'h0C;

    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUP_BASE   = 21'h10000;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } utf8_t;

    // one decoded item's results, bytes[0] goes out first
    typedef struct packed {
        logic [2:0]       cnt;
        kind_t            kind;
        logic [LEN_W-1:0] len;
        logic [3:0][7:0]  bytes;
    } burst_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u.bytes = '0;
        if (cp < 21'h80) begin
            u.cnt      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.cnt      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.cnt      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.cnt      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

/* rtl/core/json_string_unescape.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string literal decoder with UTF-8 output.
// ----------------------------------------------------------------------------
// Input beats carry one source byte (s_tdata) or, with s_tuser set, the end
// of the source. Output beats carry decoded bytes (m_tuser = data), a close
// beat with the decoded length, or an error beat; m_tlast marks the final
// beat caused by one input beat.
// An accepted beat is first held in the input register, then the scanner
// updates its state and fills the result register, from which the first
// result beat is sent.
// Throughput: one input beat per cycle while each beat gives at most one
// result and m_tready stays high. A beat that gives k results (up to four,
// for a \u escape) holds the result register while they go out, one beat each.
// When the receiver stalls, the input register still takes one more beat,
// then s_tready drops until the result register drains.
// Reset (aresetn low, synchronous) empties both registers and puts the
// scanner back to idle, waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic        s_tuser,   // [0] input_done
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] decoded_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_done_reg;
    logic       burst_free;
    logic       advance;
    burst_t     burst;

    assign advance  = in_valid_reg && burst_free;
    assign s_tready = !in_valid_reg || burst_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_done_reg <= s_tuser;
        end
    end

    jsu_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .src_byte   (in_byte_reg),
        .input_done (in_done_reg),
        .burst      (burst)
    );

    jsu_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .burst    (burst),
        .free     (burst_free),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

`include "json_string_unescape_assert.svh"

    `JSU_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `JSU_ASSERT(a_burst_cont, m_tvalid && !m_tlast |=> m_tvalid, "result burst broken")
    `JSU_ASSERT(a_ctrl_alone, m_tvalid && m_tuser != KIND_DATA |-> m_tlast, "end or error not last")
    `JSU_ASSERT(a_len_end, m_tvalid && m_tuser != KIND_END |-> m_tdata[23:8] == 16'd0, "stray length")

endmodule

/* rtl/core/jsu_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Scanner state machine: one source byte in, up to four results out.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] src_byte,
    input  logic       input_done,
    output burst_t     burst
);

    localparam int LW = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    mode_t                  mode_reg, mode_next;
    logic [15:0]            high_reg, high_next;
    logic [15:0]            low_reg, low_next;
    logic [1:0]             hex_cnt_reg, hex_cnt_next;
    logic [LENGTH_BITS-1:0] byte_cnt_reg, byte_cnt_next;

    hex_t                   hv;
    utf8_t                  enc;
    logic [15:0]            code_hi;
    logic [15:0]            code_lo;
    logic [LW-1:0]          cnt_wide;
    logic [LEN_W-1:0]       len_sat;
    logic [LENGTH_BITS:0]   cnt_sum;
    logic [2:0]             data_n;
    logic                   clear;

    assign hv       = hex_value(src_byte);
    assign code_hi  = {high_reg[11:0], hv.val};
    assign code_lo  = {low_reg[11:0], hv.val};
    assign cnt_wide = LW'(byte_cnt_reg);
    assign len_sat  = (cnt_wide > LW'(16'hFFFF)) ? 16'hFFFF : cnt_wide[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            high_reg     <= '0;
            low_reg      <= '0;
            hex_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            hex_cnt_reg  <= hex_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        hex_cnt_next = hex_cnt_reg;
        burst        = '0;
        burst.kind   = KIND_DATA;
        enc          = '0;
        clear        = 1'b0;

        if (input_done) begin
            burst.cnt  = 3'd1;
            burst.kind = KIND_ERR;
            clear      = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (src_byte == CH_QUOTE) begin
                        mode_next = MODE_STR;
                        clear     = 1'b1;
                    end else if (!(src_byte == CH_SPACE || src_byte == CH_TAB ||
                                   src_byte == CH_CR || src_byte == CH_LF)) begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_ERR;
                        clear      = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (src_byte == CH_QUOTE) begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_END;
                        burst.len  = len_sat;
                        clear      = 1'b1;
                    end else if (src_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        burst.cnt      = 3'd1;
                        burst.bytes[0] = src_byte;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_STR;
                    burst.cnt = 3'd1;
                    case (src_byte) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: burst.bytes[0] = src_byte;
                        CH_B: burst.bytes[0] = CTL_BS;
                        CH_F: burst.bytes[0] = CTL_FF;
                        CH_N: burst.bytes[0] = CH_LF;
                        CH_R: burst.bytes[0] = CH_CR;
                        CH_T: burst.bytes[0] = CH_TAB;
                        CH_U: begin
                            burst.cnt    = 3'd0;
                            mode_next    = MODE_HEX_HI;
                            high_next    = '0;
                            hex_cnt_next = '0;
                        end
                        default: begin
                            burst.kind = KIND_ERR;
                            clear      = 1'b1;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    if (!hv.ok) begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_ERR;
                        clear      = 1'b1;
                    end else begin
                        high_next = code_hi;
                        if (hex_cnt_reg != 2'd3) begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end else begin
                            hex_cnt_next = '0;
                            if (code_hi >= HI_SUR_MIN && code_hi <= HI_SUR_MAX) begin
                                mode_next = MODE_SUR_BS;
                            end else begin
                                enc         = utf8_encode({5'd0, code_hi});
                                burst.cnt   = enc.cnt;
                                burst.bytes = enc.bytes;
                                mode_next   = MODE_STR;
                            end
                        end
                    end
                end
                MODE_SUR_BS: begin
                    if (src_byte == CH_BSLASH) begin
                        mode_next = MODE_SUR_U;
                    end else begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_ERR;
                        clear      = 1'b1;
                    end
                end
                MODE_SUR_U: begin
                    if (src_byte == CH_U) begin
                        mode_next    = MODE_HEX_LO;
                        low_next     = '0;
                        hex_cnt_next = '0;
                    end else begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_ERR;
                        clear      = 1'b1;
                    end
                end
                MODE_HEX_LO: begin
                    if (!hv.ok) begin
                        burst.cnt  = 3'd1;
                        burst.kind = KIND_ERR;
                        clear      = 1'b1;
                    end else begin
                        low_next = code_lo;
                        if (hex_cnt_reg != 2'd3) begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end else if (code_lo < LO_SUR_MIN || code_lo > LO_SUR_MAX) begin
                            burst.cnt  = 3'd1;
                            burst.kind = KIND_ERR;
                            clear      = 1'b1;
                        end else begin
                            hex_cnt_next = '0;
                            enc          = utf8_encode(SUP_BASE +
                                                       {1'b0, high_reg[9:0], code_lo[9:0]});
                            burst.cnt    = enc.cnt;
                            burst.bytes  = enc.bytes;
                            mode_next    = MODE_STR;
                        end
                    end
                end
                default: begin
                    burst.cnt  = 3'd1;
                    burst.kind = KIND_ERR;
                    clear      = 1'b1;
                end
            endcase
        end

        data_n  = (burst.kind == KIND_DATA) ? burst.cnt : 3'd0;
        cnt_sum = {1'b0, byte_cnt_reg} + (LENGTH_BITS + 1)'(data_n);

        if (clear) begin
            mode_next     = (mode_reg == MODE_IDLE && burst.kind == KIND_DATA) ?
                            MODE_STR : MODE_IDLE;
            high_next     = '0;
            low_next      = '0;
            hex_cnt_next  = '0;
            byte_cnt_next = '0;
        end else if (cnt_sum > {1'b0, CNT_MAX}) begin
            byte_cnt_next = CNT_MAX;
        end else begin
            byte_cnt_next = cnt_sum[LENGTH_BITS-1:0];
        end
    end

endmodule

/* rtl/core/jsu_burst.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_burst
// Result register: holds one item's results and sends them one beat each.
// ----------------------------------------------------------------------------
module jsu_burst import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  burst_t      burst,
    output logic        free,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] decoded_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic [2:0]       cnt_reg;
    kind_t            kind_reg;
    logic [LEN_W-1:0] len_reg;
    logic [3:0][7:0]  bytes_reg;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = {len_reg, bytes_reg[0]};
    assign m_tuser  = kind_reg;
    assign free     = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst.cnt;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= burst.kind;
            len_reg   <= burst.len;
            bytes_reg <= burst.bytes;
        end else if (m_tvalid && m_tready) begin
            bytes_reg <= {8'h00, bytes_reg[3:1]};
        end
    end

endmodule
